// ----- rtl/core/keypad_event_auto_repeat_top_assert.svh -----
// Assertion macros used by the checker of the keypad auto-repeat block.
`ifndef KEYPAD_EVENT_AUTO_REPEAT_TOP_ASSERT_SVH
`define KEYPAD_EVENT_AUTO_REPEAT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/kea_pkg.sv -----
package kea_pkg;

	// Phase of the auto-repeat timer.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_REPEAT = 2'd2
	} phase_t;

	// Logical buttons decoded from the column-0 keys.
	typedef enum logic [2:0] {
		BTN_NONE   = 3'd0,
		BTN_UP     = 3'd1,
		BTN_DOWN   = 3'd2,
		BTN_LEFT   = 3'd3,
		BTN_RIGHT  = 3'd4,
		BTN_SELECT = 3'd5,
		BTN_VIEW   = 3'd6
	} button_t;

	// Kinds of report delivered on the output channel.
	typedef enum logic [1:0] {
		REP_PRESS   = 2'd0,
		REP_REPEAT  = 2'd1,
		REP_RELEASE = 2'd2
	} report_t;

	// Operations passed from the classifier to the executor.
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PRESS   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ENABLE   = 2'd0,
		CFG_DELAY    = 2'd1,
		CFG_INTERVAL = 2'd2
	} cfg_index_t;

	localparam int CFG_DATA_W = 16;
	localparam int TIMER_W    = 16;

	// One classified transaction waiting in the queue.
	typedef struct packed {
		op_t     op;
		button_t btn;
	} cmd_t;

	// Configuration as seen by the front and back parts.
	typedef struct packed {
		logic                 enable;
		logic [TIMER_W-1:0]   delay;
		logic [TIMER_W-1:0]   interval;
		logic                 clear;
	} cfg_t;

	// Up, down, left and right auto-repeat; select and view switch do not.
	function automatic logic is_direction(button_t b);
		return (b == BTN_UP) || (b == BTN_DOWN) || (b == BTN_LEFT) || (b == BTN_RIGHT);
	endfunction

	// A period register of zero behaves as a single tick.
	function automatic logic [TIMER_W-1:0] load_value(logic [TIMER_W-1:0] v);
		return (v == '0) ? TIMER_W'(1) : v;
	endfunction

endpackage

// ----- rtl/core/keypad_event_auto_repeat_top.sv -----
// Keypad event auto-repeat.
// Input channel (in_valid/in_stall, kind, event_byte) carries keypad controller
// event bytes (kind 0) and one-millisecond ticks (kind 1). A transaction is taken
// at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall, report, button, flush_queue) carries press,
// auto-repeat and release reports, zero or one for each input transaction, in order.
// A front classifier decodes keys and drops events that can cause nothing; a queue
// of QUEUE_DEPTH entries feeds the executor, which holds the key and repeat timer.
// Throughput is one transaction per cycle while out_stall is low. The queue entry is
// written at the accepting edge, and the report enters the output register when the
// executor takes that entry from the queue.
// When out_stall is high with a report held, the report holds, the executor pauses,
// and in_stall rises once the queue is full.
// Configuration writes (cfg_write, cfg_index, cfg_data) land at once: enable,
// repeat delay and repeat interval in ticks. Clearing enable releases the held key
// without a report. Write only while the block is idle.
// Reset (arst_n low) empties queue and output, clears the key and timer state and
// restores enable 1, delay 500 and interval 50.
module keypad_event_auto_repeat_top
	import kea_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [7:0]            event_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            report,
	output logic [2:0]            button,
	output logic                  flush_queue
);

	logic               enable_q;
	logic [TIMER_W-1:0] delay_q;
	logic [TIMER_W-1:0] interval_q;
	cfg_t               cfg;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	cmd_t               cmd_in;
	cmd_t               cmd_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			delay_q    <= TIMER_W'(500);
			interval_q <= TIMER_W'(50);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ENABLE:   enable_q   <= cfg_data[0];
				CFG_DELAY:    delay_q    <= cfg_data[TIMER_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[TIMER_W-1:0];
				default:      enable_q   <= enable_q;
			endcase
		end
	end

	// A write of zero to enable sends the executor back to idle.
	always_comb begin
		cfg.enable   = enable_q;
		cfg.delay    = delay_q;
		cfg.interval = interval_q;
		cfg.clear    = cfg_write && (cfg_index == CFG_ENABLE) && !cfg_data[0];
	end

	kea_front u_front (
		.in_valid   (in_valid),
		.kind       (kind),
		.event_byte (event_byte),
		.cfg        (cfg),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.push       (push),
		.cmd        (cmd_in)
	);

	kea_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (pop),
		.rdata  (cmd_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	kea_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_out),
		.q_empty     (q_empty),
		.cfg         (cfg),
		.out_stall   (out_stall),
		.pop         (pop),
		.out_valid   (out_valid),
		.report      (report),
		.button      (button),
		.flush_queue (flush_queue)
	);

endmodule

// ----- rtl/core/kea_front.sv -----
module kea_front
	import kea_pkg::*;
(
	input  logic       in_valid,
	input  logic       kind,
	input  logic [7:0] event_byte,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       in_stall,
	output logic       push,
	output cmd_t       cmd
);

	// Key number plus one for each column-0 key that is in use.
	localparam logic [6:0] KEYCODE_UP     = 7'd1;
	localparam logic [6:0] KEYCODE_DOWN   = 7'd11;
	localparam logic [6:0] KEYCODE_LEFT   = 7'd21;
	localparam logic [6:0] KEYCODE_RIGHT  = 7'd31;
	localparam logic [6:0] KEYCODE_SELECT = 7'd41;
	localparam logic [6:0] KEYCODE_VIEW   = 7'd61;

	button_t btn;

	// Decode the key number; every other key, the sixth column-0 key included, maps to none.
	always_comb begin
		case (event_byte[6:0])
			KEYCODE_UP:     btn = BTN_UP;
			KEYCODE_DOWN:   btn = BTN_DOWN;
			KEYCODE_LEFT:   btn = BTN_LEFT;
			KEYCODE_RIGHT:  btn = BTN_RIGHT;
			KEYCODE_SELECT: btn = BTN_SELECT;
			KEYCODE_VIEW:   btn = BTN_VIEW;
			default:        btn = BTN_NONE;
		endcase
	end

	// Ticks always go to the queue; key events only when enabled and mapped.
	// Transactions that cannot cause anything are accepted and dropped here.
	always_comb begin
		in_stall = q_full;
		push     = in_valid && !q_full && (kind || (cfg.enable && (btn != BTN_NONE)));
		if (kind) begin
			cmd.op = OP_TICK;
		end else if (event_byte[7]) begin
			cmd.op = OP_PRESS;
		end else begin
			cmd.op = OP_RELEASE;
		end
		cmd.btn = btn;
	end

endmodule

// ----- rtl/core/kea_queue.sv -----
module kea_queue
	import kea_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/kea_back.sv -----
module kea_back
	import kea_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       q_empty,
	input  cfg_t       cfg,
	input  logic       out_stall,
	output logic       pop,
	output logic       out_valid,
	output logic [1:0] report,
	output logic [2:0] button,
	output logic       flush_queue
);

	phase_t             phase_q, phase_d;
	button_t            held_q, held_d;
	logic               running_q, running_d;
	logic [TIMER_W-1:0] ticks_q, ticks_d;
	logic [TIMER_W-1:0] period_q, period_d;

	logic    out_valid_q;
	report_t report_q, report_d;
	button_t button_q, button_d;
	logic    flush_q, flush_d;
	logic    emit;

	// Execute the head transaction whenever the output register is free or being emptied.
	assign pop = !q_empty && (!out_valid_q || !out_stall);

	// Next-state and result logic for the held key and repeat timer.
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		running_d = running_q;
		ticks_d   = ticks_q;
		period_d  = period_q;
		emit      = 1'b0;
		report_d  = REP_PRESS;
		button_d  = cmd.btn;
		flush_d   = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				if (running_q) begin
					if (ticks_q > TIMER_W'(1)) begin
						ticks_d = ticks_q - TIMER_W'(1);
					end else begin
						ticks_d = load_value(period_q);
						if (is_direction(held_q)) begin
							// The first expiry ends the initial delay.
							if (phase_q == PH_WAIT) begin
								phase_d  = PH_REPEAT;
								period_d = load_value(cfg.interval);
								ticks_d  = load_value(cfg.interval);
							end
							emit     = 1'b1;
							report_d = REP_REPEAT;
							button_d = held_q;
						end
					end
				end
			end
			OP_PRESS: begin
				// A second press of the held key while timing is swallowed.
				if (!((held_q == cmd.btn) && (phase_q != PH_IDLE))) begin
					held_d = cmd.btn;
					if (is_direction(cmd.btn)) begin
						phase_d   = PH_WAIT;
						period_d  = load_value(cfg.delay);
						ticks_d   = load_value(cfg.delay);
						running_d = 1'b1;
					end
					emit     = 1'b1;
					report_d = REP_PRESS;
				end
			end
			OP_RELEASE: begin
				// Only a release of the held key counts.
				if (held_q == cmd.btn) begin
					held_d    = BTN_NONE;
					phase_d   = PH_IDLE;
					running_d = 1'b0;
					ticks_d   = '0;
					emit      = 1'b1;
					report_d  = REP_RELEASE;
					flush_d   = is_direction(cmd.btn);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Key and timer state; disabling the block returns it to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			held_q    <= BTN_NONE;
			running_q <= 1'b0;
			ticks_q   <= '0;
			period_q  <= '0;
		end else if (cfg.clear) begin
			phase_q   <= PH_IDLE;
			held_q    <= BTN_NONE;
			running_q <= 1'b0;
			ticks_q   <= '0;
		end else if (pop) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			running_q <= running_d;
			ticks_q   <= ticks_d;
			period_q  <= period_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			report_q <= report_d;
			button_q <= button_d;
			flush_q  <= flush_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign report      = report_q;
	assign button      = button_q;
	assign flush_queue = flush_q;

endmodule

// ----- rtl/core/kea_checker.sv -----
`include "keypad_event_auto_repeat_top_assert.svh"

module kea_checker
	import kea_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] report,
	input logic [2:0] button,
	input logic       flush_queue
);

	// A stalled report stays put until it is taken.
	`KEA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(report) && $stable(button) && $stable(flush_queue), "stalled report changed")

	// Every report names a real button and a defined report kind.
	`KEA_ASSERT_NOW(a_out_legal, clk, arst_n, out_valid, (button != BTN_NONE) && (button != 3'd7) && ((report == REP_PRESS) || (report == REP_REPEAT) || (report == REP_RELEASE)), "illegal report or button")

	// Only direction keys auto-repeat, and a repeat never flushes the queue.
	`KEA_ASSERT_NOW(a_repeat_dir, clk, arst_n, out_valid && (report == REP_REPEAT), !flush_queue && ((button == BTN_UP) || (button == BTN_DOWN) || (button == BTN_LEFT) || (button == BTN_RIGHT)), "repeat of a non-direction key")

	// A queue flush comes only with the release of a direction key.
	`KEA_ASSERT_NOW(a_flush_release, clk, arst_n, out_valid && flush_queue, (report == REP_RELEASE) && ((button == BTN_UP) || (button == BTN_DOWN) || (button == BTN_LEFT) || (button == BTN_RIGHT)), "flush without a direction release")

endmodule

bind keypad_event_auto_repeat_top kea_checker u_kea_checker (.*);
